[hw/rtl/hsa_pkg.sv]
// Shared types and constants for the handle slot allocator.
package hsa_pkg;

   localparam int POOL_SLOTS   = 64;
   localparam int HANDLE_COUNT = 64;
   localparam int SLOT_W       = $clog2(POOL_SLOTS);
   localparam int HANDLE_W     = $clog2(HANDLE_COUNT);
   localparam int COUNT_W      = $clog2(POOL_SLOTS + 1);
   localparam int FUNC_W       = 2;
   localparam int STATUS_W     = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_QUERY = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_UNMAPPED = 2'd2
   } status_type;

   // Handle map update from the execute stage
   typedef struct packed {
      logic                en;
      logic                valid;
      logic [HANDLE_W-1:0] handle;
      logic [SLOT_W-1:0]   slot;
   } map_wr_type;

endpackage

[hw/rtl/hsa_first_free.sv]
// Priority encoder that finds the lowest free slot in the used bitmap.
module hsa_first_free (
   input  logic [hsa_pkg::POOL_SLOTS-1:0] used,
   output logic                           found,
   output logic [hsa_pkg::SLOT_W-1:0]     slot
);
   import hsa_pkg::*;

   // Scan from the top so the lowest free slot wins
   always_comb begin
      found = 1'b0;
      slot  = '0;
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            found = 1'b1;
            slot  = SLOT_W'(i);
         end
      end
   end

endmodule

[hw/rtl/hsa_map.sv]
// Handle-to-slot map: slot memory with registered read, valid bits in flops.
module hsa_map (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [hsa_pkg::HANDLE_W-1:0] rd_handle,
   output logic [hsa_pkg::SLOT_W-1:0]   rd_slot,
   input  logic [hsa_pkg::HANDLE_W-1:0] look_handle,
   output logic                         look_valid,
   input  hsa_pkg::map_wr_type          wr
);
   import hsa_pkg::*;

   logic [SLOT_W-1:0]       slot_mem [HANDLE_COUNT];
   logic [SLOT_W-1:0]       rd_slot_ff;
   logic [HANDLE_COUNT-1:0] valid_ff;
   logic [HANDLE_COUNT-1:0] valid_in;
   logic                    mem_we;

   assign mem_we = wr.en && wr.valid;

   // Write the slot number on allocate
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr.handle] <= wr.slot;
      end
   end

   // Read on accept; forward a same-cycle write to the same handle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (mem_we && (wr.handle == rd_handle)) begin
            rd_slot_ff <= wr.slot;
         end else begin
            rd_slot_ff <= slot_mem[rd_handle];
         end
      end
   end

   assign rd_slot = rd_slot_ff;

   // Set the mapping on allocate, drop it on free
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.handle] = wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign look_valid = valid_ff[look_handle];

endmodule

[hw/rtl/handle_slot_allocator.sv]
// Top level of the handle slot allocator.
// The allocator takes one request beat per cycle and returns one result beat per
// request. The request is registered into the execute stage at the accepting edge,
// and the result register is loaded when the beat leaves that stage. At the
// accepting edge the handle's slot number is read from the map memory. In the
// following cycle a single execute stage does the rest. It finds the lowest free
// slot with a priority encoder over the 64-bit used bitmap, updates the bitmap,
// map and live count, and loads the result register. A stalled result holds the
// execute stage, and the request side stalls once that stage is also full. Reset
// clears the bitmap, the map valid bits and the count at once, so the block
// accepts requests in the first cycle after reset.
module handle_slot_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hsa_pkg::FUNC_W-1:0]   req_func,
   input  logic [hsa_pkg::HANDLE_W-1:0] req_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hsa_pkg::STATUS_W-1:0] rsp_status,
   output logic [hsa_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_in_use,
   output logic [hsa_pkg::COUNT_W-1:0]  rsp_live_count
);
   import hsa_pkg::*;

   logic                  s1_valid_ff;
   logic [FUNC_W-1:0]     s1_func_ff;
   logic [HANDLE_W-1:0]   s1_handle_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic                  rsp_in_use_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [POOL_SLOTS-1:0] used_ff;
   logic [POOL_SLOTS-1:0] used_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;

   logic                  advance;
   logic                  fire;
   logic                  accept;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_slot;
   logic                  mapped;
   logic [SLOT_W-1:0]     mapped_slot;
   map_wr_type            map_wr;
   status_type            status_in;
   logic [SLOT_W-1:0]     slot_in;
   logic                  in_use_in;

   // Handshake: the execute stage moves when the result register can take a beat
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   hsa_first_free u_first_free (
      .used  (used_ff),
      .found (free_found),
      .slot  (free_slot)
   );

   hsa_map u_map (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_handle   (req_handle),
      .rd_slot     (mapped_slot),
      .look_handle (s1_handle_ff),
      .look_valid  (mapped),
      .wr          (map_wr)
   );

   // Execute: decide the result and the state updates
   always_comb begin
      used_in       = used_ff;
      count_in      = count_ff;
      map_wr.en     = 1'b0;
      map_wr.valid  = 1'b0;
      map_wr.handle = s1_handle_ff;
      map_wr.slot   = free_slot;
      status_in     = ST_OK;
      slot_in       = '0;
      in_use_in     = mapped;
      case (s1_func_ff)
         FUNC_ALLOC: begin
            if (free_found) begin
               used_in[free_slot] = 1'b1;
               if (count_ff < COUNT_W'(POOL_SLOTS)) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               map_wr.en    = fire;
               map_wr.valid = 1'b1;
               slot_in      = free_slot;
               in_use_in    = 1'b1;
            end else begin
               status_in = ST_FULL;
            end
         end
         FUNC_FREE: begin
            in_use_in = 1'b0;
            if (mapped) begin
               used_in[mapped_slot] = 1'b0;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
               map_wr.en = fire;
               slot_in   = mapped_slot;
            end else begin
               status_in = ST_UNMAPPED;
            end
         end
         default: begin
            // query, and the unused selector acts as a query
            if (mapped) begin
               slot_in = mapped_slot;
            end
         end
      endcase
   end

   // Hold the request in the execute stage; load whenever the stage can take a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff   <= req_func;
         s1_handle_ff <= req_handle;
      end
   end

   // Commit bitmap and count when the beat leaves the execute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else if (fire) begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= status_in;
         rsp_slot_ff   <= slot_in;
         rsp_in_use_ff <= in_use_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_in_use     = rsp_in_use_ff;
   assign rsp_live_count = rsp_count_ff;

endmodule

[hw/rtl/hsa_checker.sv]
// Port-level assertions for the handle slot allocator, bound to the top level.
module hsa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [hsa_pkg::STATUS_W-1:0] rsp_status,
   input logic [hsa_pkg::SLOT_W-1:0]   rsp_slot,
   input logic                         rsp_in_use,
   input logic [hsa_pkg::COUNT_W-1:0]  rsp_live_count
);
   import hsa_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_in_use) && $stable(rsp_live_count))
      else $error("result beat changed while stalled");

   // Drop results out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A full pool means every slot is counted
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_live_count == COUNT_W'(POOL_SLOTS))
      else $error("pool full reported with free slots");

   // A free of an unmapped handle reports no slot and no mapping
   a_unmapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNMAPPED) |-> (rsp_slot == '0) && !rsp_in_use)
      else $error("unmapped free reported a slot");

   // Never count more slots than the pool holds
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_live_count <= COUNT_W'(POOL_SLOTS))
      else $error("live count out of range");

endmodule

bind handle_slot_allocator hsa_checker u_hsa_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_slot       (rsp_slot),
   .rsp_in_use     (rsp_in_use),
   .rsp_live_count (rsp_live_count)
);

[sim/handle_slot_allocator_test.sv]
// Self-checking testbench for the handle slot allocator with a shadow slot pool.
module handle_slot_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hsa_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;  // unused selector, acts as a query
   localparam logic [HANDLE_W-1:0] LAST_HANDLE = HANDLE_W'(HANDLE_COUNT - 1);
   localparam int IDLE_LIMIT = 1000;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic                in_use;
      logic [COUNT_W-1:0]  live_count;
   } slot_result_type;

   // Shadow copy of the pool: predicts each result and checks the returned beats
   class slot_ledger;
      logic               slot_busy[POOL_SLOTS];
      logic               map_live[HANDLE_COUNT];
      logic [SLOT_W-1:0]  map_target[HANDLE_COUNT];
      logic [COUNT_W-1:0] live_slots;
      slot_result_type    pending_results[$];
      int mismatches, requests, results, n_full, n_unmapped, n_realloc, peak_live;

      function new();
         foreach (slot_busy[i]) slot_busy[i] = 1'b0;
         foreach (map_live[i]) begin
            map_live[i]   = 1'b0;
            map_target[i] = '0;
         end
         live_slots = '0;
         mismatches = 0;
         requests   = 0;
         results    = 0;
         n_full     = 0;
         n_unmapped = 0;
         n_realloc  = 0;
         peak_live  = 0;
      endfunction

      // Apply one accepted request to the shadow pool and queue its result
      function void note_request(logic [FUNC_W-1:0] func, logic [HANDLE_W-1:0] handle);
         slot_result_type res;
         int free_slot;
         res = '0;
         free_slot = -1;
         requests++;
         case (func)
            FUNC_ALLOC: begin
               for (int i = POOL_SLOTS - 1; i >= 0; i--)
                  if (!slot_busy[i]) free_slot = i;
               if (free_slot < 0) begin
                  res.status = ST_FULL;
                  res.in_use = map_live[handle];
                  n_full++;
               end else begin
                  // an overwritten mapping leaves its old slot in use
                  if (map_live[handle]) n_realloc++;
                  slot_busy[free_slot] = 1'b1;
                  map_live[handle]     = 1'b1;
                  map_target[handle]   = free_slot[SLOT_W-1:0];
                  if (live_slots < POOL_SLOTS) live_slots++;
                  res.status = ST_OK;
                  res.slot   = free_slot[SLOT_W-1:0];
                  res.in_use = 1'b1;
               end
            end
            FUNC_FREE: begin
               if (!map_live[handle]) begin
                  res.status = ST_UNMAPPED;
                  n_unmapped++;
               end else begin
                  slot_busy[map_target[handle]] = 1'b0;
                  res.status         = ST_OK;
                  res.slot           = map_target[handle];
                  map_live[handle]   = 1'b0;
                  map_target[handle] = '0;
                  if (live_slots > 0) live_slots--;
               end
            end
            default: begin
               res.status = ST_OK;
               if (map_live[handle]) begin
                  res.slot   = map_target[handle];
                  res.in_use = 1'b1;
               end
            end
         endcase
         res.live_count = live_slots;
         if (live_slots > peak_live) peak_live = live_slots;
         pending_results.push_back(res);
      endfunction

      // Compare one returned beat against the oldest queued result
      function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                 logic in_use, logic [COUNT_W-1:0] live_count);
         slot_result_type res;
         results++;
         if (pending_results.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatches++;
            return;
         end
         res = pending_results.pop_front();
         if (status !== res.status) begin
            $error("status: expected %0d, got %0d", res.status, status);
            mismatches++;
         end
         if (slot !== res.slot) begin
            $error("slot: expected %0d, got %0d", res.slot, slot);
            mismatches++;
         end
         if (in_use !== res.in_use) begin
            $error("in_use: expected %0d, got %0d", res.in_use, in_use);
            mismatches++;
         end
         if (live_count !== res.live_count) begin
            $error("live_count: expected %0d, got %0d", res.live_count, live_count);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = FUNC_ALLOC;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_in_use;
   logic [COUNT_W-1:0]  rsp_live_count;

   slot_ledger ledger = new();
   bit sender_quiet = 1'b0;

   handle_slot_allocator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_handle     (req_handle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_in_use     (rsp_in_use),
      .rsp_live_count (rsp_live_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check every result beat the receiver takes
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_result(rsp_status, rsp_slot, rsp_in_use, rsp_live_count);
   end

   // Receiver: alternate ready stretches with stalls, mostly short, a few long
   initial begin : result_stall
      bit stall_on;
      int len;
      while (reset) @(posedge clock);
      forever begin
         stall_on = ($urandom_range(2) == 0);
         if (stall_on)
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         else
            len = $urandom_range(1, 30);
         rsp_stall <= stall_on;
         repeat (len) @(posedge clock);
      end
   end

   // End the run when no beat moves on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Drop valid for a random gap: mostly none, some short, a few long
   task automatic sender_gap();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 55) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one request beat and hold it until the block takes it
   task automatic send_request(logic [FUNC_W-1:0] func, logic [HANDLE_W-1:0] handle);
      req_valid  <= 1'b1;
      req_func   <= func;
      req_handle <= handle;
      do @(posedge clock); while (req_stall);
      ledger.note_request(func, handle);
      if (!sender_quiet) sender_gap();
   endtask

   // Hold off the sender until every queued result has come back
   task automatic wait_results();
      req_valid <= 1'b0;
      while (ledger.pending_results.size() != 0) @(posedge clock);
   endtask

   // Pick a handle whose mapping state matches, probing from a random start
   function automatic logic [HANDLE_W-1:0] pick_handle(bit want_mapped);
      logic [HANDLE_W-1:0] h;
      h = HANDLE_W'($urandom_range(HANDLE_COUNT - 1));
      for (int tries = 0; tries < HANDLE_COUNT; tries++) begin
         if (ledger.map_live[h] == want_mapped) return h;
         h = h + 1'b1;
      end
      return h;
   endfunction

   // Random round: allocations mostly on free handles, frees mostly on mapped ones
   task automatic run_round(int items, int alloc_pct, int free_pct, bit quiet);
      int r;
      logic [FUNC_W-1:0]   func;
      logic [HANDLE_W-1:0] handle;
      sender_quiet = quiet;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(99);
         if (r < alloc_pct) begin
            func   = FUNC_ALLOC;
            handle = ($urandom_range(49) == 0) ? HANDLE_W'($urandom_range(HANDLE_COUNT - 1))
                                               : pick_handle(1'b0);
         end else if (r < alloc_pct + free_pct) begin
            func   = FUNC_FREE;
            handle = ($urandom_range(9) == 0) ? HANDLE_W'($urandom_range(HANDLE_COUNT - 1))
                                              : pick_handle(1'b1);
         end else begin
            func   = ($urandom_range(3) == 0) ? FUNC_SPARE : FUNC_QUERY;
            handle = HANDLE_W'($urandom_range(HANDLE_COUNT - 1));
         end
         send_request(func, handle);
      end
      sender_quiet = 1'b0;
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pool, unmapped free, extremes of handle, spare selector,
      // re-allocation that strands a slot, reuse of the lowest freed slot
      send_request(FUNC_QUERY, HANDLE_W'(0));
      send_request(FUNC_FREE, HANDLE_W'(17));
      send_request(FUNC_ALLOC, HANDLE_W'(0));
      send_request(FUNC_ALLOC, LAST_HANDLE);
      send_request(FUNC_QUERY, HANDLE_W'(0));
      send_request(FUNC_QUERY, LAST_HANDLE);
      send_request(FUNC_SPARE, LAST_HANDLE);
      send_request(FUNC_SPARE, HANDLE_W'(9));
      send_request(FUNC_ALLOC, HANDLE_W'(0));
      send_request(FUNC_QUERY, HANDLE_W'(0));
      send_request(FUNC_FREE, LAST_HANDLE);
      send_request(FUNC_FREE, LAST_HANDLE);
      send_request(FUNC_ALLOC, HANDLE_W'(42));
      send_request(FUNC_FREE, HANDLE_W'(0));
      send_request(FUNC_QUERY, HANDLE_W'(0));
      send_request(FUNC_ALLOC, HANDLE_W'(21));
      send_request(FUNC_FREE, HANDLE_W'(42));
      send_request(FUNC_FREE, HANDLE_W'(21));
      wait_results();

      // random: fill to full, drain, mix back to back, then repeat
      run_round(150, 75, 10, 1'b0);
      run_round(150, 15, 70, 1'b0);
      wait_results();
      run_round(150, 40, 40, 1'b1);
      run_round(120, 80, 5, 1'b0);
      wait_results();
      run_round(130, 20, 65, 1'b0);

      wait_results();
      repeat (8) @(posedge clock);

      $display("Ran %0d requests, checked %0d results: %0d pool full, %0d unmapped frees,",
               ledger.requests, ledger.results, ledger.n_full, ledger.n_unmapped);
      $display("%0d re-allocations, peak live count %0d, %0d mismatches",
               ledger.n_realloc, ledger.peak_live, ledger.mismatches);
      if (ledger.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/hsa_pkg.sv
hw/rtl/hsa_first_free.sv
hw/rtl/hsa_map.sv
hw/rtl/handle_slot_allocator.sv
hw/rtl/hsa_checker.sv
sim/handle_slot_allocator_test.sv
